// File: hw/rtl/sidt_pkg.sv
// Shared constants, codes and helper functions for the sidereal time block.
// Used by the fraction divider submodule, the top level and the testbench.
// No dependencies.
package sidt_pkg;

  localparam int FRAC_BITS = 48;

  localparam logic [63:0] TICKS_PER_DAY = 64'd5184000;
  localparam logic [63:0] LON_DEN       = 64'd1296000;
  localparam logic [63:0] T_DEN         = 64'd73050;
  localparam logic [63:0] LIN_DEN       = 64'd63115200000;
  localparam logic [63:0] LIN_MUL       = 64'd86401848;

  localparam int LON_DW = $clog2(LON_DEN);
  localparam int T_DW   = $clog2(T_DEN);
  localparam int LIN_DW = $clog2(LIN_DEN);
  localparam int UT_DW  = $clog2(TICKS_PER_DAY);

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_LON_DEG = 2'd0;
  localparam logic [1:0] REG_LON_MIN = 2'd1;
  localparam logic [1:0] REG_LON_SEC = 2'd2;

  // floor(num * 2^FRAC_BITS / den) by restoring long division, for num < den.
  function automatic logic [FRAC_BITS-1:0] quot_q(input logic [63:0] num,
                                                  input logic [63:0] den);
    logic [63:0] r;
    logic [FRAC_BITS-1:0] q;
    r = num;
    q = '0;
    for (int i = 0; i < FRAC_BITS; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  localparam logic [FRAC_BITS-1:0] C_GMST0   = quot_q(64'd24110548, 64'd86400000);
  localparam logic [FRAC_BITS-1:0] C_QUAD    = quot_q(64'd93104, 64'd86400000000);
  localparam logic [FRAC_BITS-1:0] C_CUBE    = quot_q(64'd62, 64'd864000000000000);
  localparam logic [FRAC_BITS-1:0] C_UTSCALE = quot_q(64'd2737845, 64'd1000000000);

  function automatic logic [8:0] days_before(input logic [3:0] mo);
    logic [8:0] d;
    case (mo)
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

// File: hw/rtl/sidt_if.sv
// Valid/ready channel interfaces for the sidereal time block.
// Input carries a UT date and time, output carries the sidereal result.
// No dependencies.
interface sidt_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] year;
  logic [3:0]  month;
  logic [4:0]  day;
  logic [4:0]  hour;
  logic [5:0]  minute;
  logic [5:0]  second;
  modport source(output valid, year, month, day, hour, minute, second, input ready);
  modport sink(input valid, year, month, day, hour, minute, second, output ready);
endinterface

interface sidt_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] used_year;
  logic [3:0]  used_month;
  logic [4:0]  used_day;
  logic [22:0] ut_ticks;
  logic [4:0]  sid_hour;
  logic [5:0]  sid_minute;
  logic [5:0]  sid_second;
  logic [22:0] sid_ticks;
  modport source(output valid, used_year, used_month, used_day, ut_ticks, sid_hour,
                 sid_minute, sid_second, sid_ticks, input ready);
  modport sink(input valid, used_year, used_month, used_day, ut_ticks, sid_hour,
               sid_minute, sid_second, sid_ticks, output ready);
endinterface

// File: hw/rtl/sidereal_time_from_ut.sv
// Local mean sidereal time from a UT date and time, with an APB longitude port.
// The pipeline has 31 register stages; throughput one item per cycle.
// The depth comes from the 12-stage fraction dividers.
// The whole pipeline stalls only while a result sits unaccepted at the output.
// Synchronous active-low reset clears the stage valid bits and the longitude
// registers (0 degrees, 0 minutes, 0 seconds).
module sidereal_time_from_ut (
  input  logic               clk,
  input  logic               rst_n,
  sidt_in_if.sink            in_ch,
  sidt_out_if.source         out_ch,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [3:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  localparam int NSTG = 31;
  localparam int FB   = sidt_pkg::FRAC_BITS;
  localparam int PW2  = 2 * FB;

  // ---------------- configuration ----------------
  logic signed [8:0] lon_deg_r;
  logic [5:0]        lon_min_r;
  logic [5:0]        lon_sec_r;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lon_deg_r <= '0;
      lon_min_r <= '0;
      lon_sec_r <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[3:2])
        sidt_pkg::REG_LON_DEG: lon_deg_r <= pwdata[8:0];
        sidt_pkg::REG_LON_MIN: lon_min_r <= pwdata[5:0];
        sidt_pkg::REG_LON_SEC: lon_sec_r <= pwdata[5:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      sidt_pkg::REG_LON_DEG: prdata = 32'(lon_deg_r);
      sidt_pkg::REG_LON_MIN: prdata = {26'd0, lon_min_r};
      sidt_pkg::REG_LON_SEC: prdata = {26'd0, lon_sec_r};
      default:               prdata = '0;
    endcase
  end

  // ---------------- flow control ----------------
  logic [NSTG:1] vld_r;
  logic          en;

  assign en           = !vld_r[NSTG] || out_ch.ready;
  assign in_ch.ready  = en;
  assign out_ch.valid = vld_r[NSTG];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTG-1:1], in_ch.valid};
    end
  end

  // ---------------- stage 1: mapping and fallbacks ----------------
  logic [11:0] yr_m;
  logic        date_bad, time_bad, lon_ok;
  logic [11:0] lon_sub;
  logic [20:0] lon_prod, arc_c;

  always_comb begin
    if (in_ch.year <= 12'd49) begin
      yr_m = in_ch.year + 12'd2000;
    end else if (in_ch.year <= 12'd99) begin
      yr_m = in_ch.year + 12'd1900;
    end else begin
      yr_m = in_ch.year;
    end
    date_bad = (yr_m < 12'd1950) || (yr_m > 12'd2050) || (in_ch.month == 4'd0)
            || (in_ch.month > 4'd12) || (in_ch.day == 5'd0);
    time_bad = (in_ch.hour > 5'd23) || (in_ch.minute > 6'd59) || (in_ch.second > 6'd59);
    lon_ok   = (lon_deg_r >= -9'sd180) && (lon_deg_r <= 9'sd180)
            && (lon_min_r <= 6'd59) && (lon_sec_r <= 6'd59);
    lon_sub  = {6'd0, lon_min_r} * 12'd60 + {6'd0, lon_sec_r};
    lon_prod = {{12{lon_deg_r[8]}}, lon_deg_r} * 21'd3600;
    if (!lon_ok) begin
      arc_c = '0;
    end else if (lon_deg_r[8]) begin
      arc_c = lon_prod - {9'd0, lon_sub};
    end else begin
      arc_c = lon_prod + {9'd0, lon_sub};
    end
  end

  logic [11:0] yr1_r;
  logic [3:0]  mo1_r;
  logic [4:0]  da1_r;
  logic [4:0]  hh1_r;
  logic [5:0]  mi1_r, se1_r;
  logic [20:0] arc1_r;

  // ---------------- stage 2: day count, UT ticks, longitude magnitude ----------------
  logic [11:0] yq, dy;
  logic [15:0] j_c;
  logic [17:0] m_c;
  logic [16:0] ut_sec;
  logic [20:0] arc_abs;

  always_comb begin
    dy     = yr1_r - 12'd1950;
    yq     = (yr1_r - 12'd1949) >> 2;
    j_c    = 16'(sidt_pkg::days_before(mo1_r)) + 16'(da1_r) - 16'd1 + 16'(yq)
           + 16'(dy) * 16'd365;
    if (yr1_r[1:0] == 2'b00 && mo1_r > 4'd2) begin
      j_c = j_c + 16'd1;
    end
    m_c    = {1'b0, j_c, 1'b0} - 18'd36525;
    ut_sec = 17'(hh1_r) * 17'd3600 + 17'(mi1_r) * 17'd60 + 17'(se1_r);
    arc_abs = arc1_r[20] ? (21'd0 - arc1_r) : arc1_r;
  end

  logic [17:0] m2_r;
  logic [19:0] arcm_r [2:6];
  logic        aneg_r [2:24];
  logic [20:0] date_r [2:31];
  logic [22:0] tk_r   [2:31];

  // ---------------- stages 3 to 6: linear term modulo one day ----------------
  localparam logic [42:0] D43 = 43'(sidt_pkg::LIN_DEN);

  logic [17:0] m_abs;
  logic [42:0] x4_c, x5_c;
  logic [15:0] mm_r   [3:6];
  logic        mneg_r [3:24];
  logic [42:0] prod3_r, x4_r;
  logic [35:0] r5_r, lin6_r;

  always_comb begin
    m_abs = m2_r[17] ? (18'd0 - m2_r) : m2_r;
    x4_c  = prod3_r;
    for (int k = 5; k >= 3; k--) begin
      if (x4_c >= (D43 << k)) begin
        x4_c = x4_c - (D43 << k);
      end
    end
    x5_c = x4_r;
    for (int k = 2; k >= 0; k--) begin
      if (x5_c >= (D43 << k)) begin
        x5_c = x5_c - (D43 << k);
      end
    end
  end

  // ---------------- stages 7 to 18: fraction dividers ----------------
  logic [FB-1:0] lon18, q18, lin18, sut18;

  sidt_qdiv #(.DEN(sidt_pkg::LON_DEN), .STEP(4)) u_div_lon (
    .clk(clk), .en(en), .num(sidt_pkg::LON_DW'(arcm_r[6])), .quo(lon18)
  );
  sidt_qdiv #(.DEN(sidt_pkg::T_DEN), .STEP(4)) u_div_t (
    .clk(clk), .en(en), .num(sidt_pkg::T_DW'(mm_r[6])), .quo(q18)
  );
  sidt_qdiv #(.DEN(sidt_pkg::LIN_DEN), .STEP(4)) u_div_lin (
    .clk(clk), .en(en), .num(lin6_r), .quo(lin18)
  );
  sidt_qdiv #(.DEN(sidt_pkg::TICKS_PER_DAY), .STEP(4)) u_div_ut (
    .clk(clk), .en(en), .num(tk_r[6]), .quo(sut18)
  );

  // ---------------- stages 19 to 24: polynomial products ----------------
  logic [PW2-1:0] p_t2, p_t3, p_c2, p_c3, p_usc;
  logic [FB-1:0]  q_r    [19:20];
  logic [FB-1:0]  lin_r  [19:24];
  logic [FB-1:0]  lon_r  [19:24];
  logic [FB-1:0]  sut_r  [19:24];
  logic [FB-1:0]  usc_r  [21:24];
  logic [FB-1:0]  c2_r   [23:24];

  sidt_mul #(.AW(FB), .BW(FB)) u_mul_t2 (
    .clk(clk), .en(en), .a(q18), .b(q18), .p(p_t2)
  );
  sidt_mul #(.AW(FB), .BW(FB)) u_mul_usc (
    .clk(clk), .en(en), .a(sut18), .b(sidt_pkg::C_UTSCALE), .p(p_usc)
  );
  sidt_mul #(.AW(FB), .BW(FB)) u_mul_t3 (
    .clk(clk), .en(en), .a(p_t2[PW2-1:FB]), .b(q_r[20]), .p(p_t3)
  );
  sidt_mul #(.AW(FB), .BW(FB)) u_mul_c2 (
    .clk(clk), .en(en), .a(p_t2[PW2-1:FB]), .b(sidt_pkg::C_QUAD), .p(p_c2)
  );
  sidt_mul #(.AW(FB), .BW(FB)) u_mul_c3 (
    .clk(clk), .en(en), .a(p_t3[PW2-1:FB]), .b(sidt_pkg::C_CUBE), .p(p_c3)
  );

  // ---------------- stages 25 and 26: sum modulo one day ----------------
  logic [FB-1:0] c3_c, c3s_c, lonq_c, sv_c, a_c;
  logic [FB-1:0] sv25_r, a25_r, s26_r;

  always_comb begin
    c3_c   = p_c3[PW2-1:FB];
    // The cubic term is subtracted, so its sign flips against the sign of t.
    c3s_c  = mneg_r[24] ? c3_c : (FB'(0) - c3_c);
    lonq_c = aneg_r[24] ? (FB'(0) - lon_r[24]) : lon_r[24];
    sv_c   = sidt_pkg::C_GMST0 + lin_r[24] + c2_r[24] + c3s_c;
    a_c    = sut_r[24] + usc_r[24] + lonq_c;
  end

  // ---------------- stages 27 to 31: seconds, ticks, h/m/s split ----------------
  logic [FB+16:0] p_whole;
  logic [FB+22:0] p_stk;

  sidt_mul #(.AW(FB), .BW(17)) u_mul_sec (
    .clk(clk), .en(en), .a(s26_r), .b(17'd86400), .p(p_whole)
  );
  sidt_mul #(.AW(FB), .BW(23)) u_mul_tick (
    .clk(clk), .en(en), .a(s26_r), .b(23'(sidt_pkg::TICKS_PER_DAY)), .p(p_stk)
  );

  logic [16:0] w_c;
  logic [16:0] whole29_r;
  logic [22:0] stk_r [29:31];
  logic [27:0] hp_c;
  logic [4:0]  h_c;
  logic [16:0] hr_c;
  logic [4:0]  hr30_r;
  logic [11:0] rem30_r;
  logic [22:0] mp_c;
  logic [5:0]  mn_c;
  logic [11:0] sr_c;
  logic [4:0]  hr31_r;
  logic [5:0]  mn31_r, sc31_r;

  always_comb begin
    // Round half up on the fraction of a second, then fold a full day back to zero.
    w_c = p_whole[FB+16:FB] + 17'(p_whole[FB-1]);
    if (w_c >= 17'd86400) begin
      w_c = w_c - 17'd86400;
    end
    // Reciprocal estimates below may fall one short; one correction fixes them.
    hp_c = 28'(whole29_r) * 28'd1165;
    h_c  = hp_c[26:22];
    hr_c = whole29_r - 17'(h_c) * 17'd3600;
    if (hr_c >= 17'd3600) begin
      hr_c = hr_c - 17'd3600;
      h_c  = h_c + 5'd1;
    end
    mp_c = 23'(rem30_r) * 23'd1092;
    mn_c = mp_c[21:16];
    sr_c = rem30_r - 12'(mn_c) * 12'd60;
    if (sr_c >= 12'd60) begin
      sr_c = sr_c - 12'd60;
      mn_c = mn_c + 6'd1;
    end
  end

  // ---------------- pipeline registers ----------------
  always_ff @(posedge clk) begin
    if (en) begin
      // stage 1
      yr1_r  <= date_bad ? 12'd1950 : yr_m;
      mo1_r  <= date_bad ? 4'd1 : in_ch.month;
      da1_r  <= date_bad ? 5'd1 : in_ch.day;
      hh1_r  <= time_bad ? 5'd0 : in_ch.hour;
      mi1_r  <= time_bad ? 6'd0 : in_ch.minute;
      se1_r  <= time_bad ? 6'd0 : in_ch.second;
      arc1_r <= arc_c;
      // stage 2
      m2_r      <= m_c;
      arcm_r[2] <= arc_abs[19:0];
      aneg_r[2] <= arc1_r[20];
      date_r[2] <= {yr1_r, mo1_r, da1_r};
      tk_r[2]   <= 23'(ut_sec) * 23'd60;
      // stage 3
      mm_r[3]   <= m_abs[15:0];
      mneg_r[3] <= m2_r[17];
      prod3_r   <= 43'(sidt_pkg::LIN_MUL) * 43'(m_abs[15:0]);
      // stages 4 to 6
      x4_r   <= x4_c;
      r5_r   <= x5_c[35:0];
      lin6_r <= (mneg_r[5] && r5_r != 36'd0) ? (sidt_pkg::LIN_DEN[35:0] - r5_r) : r5_r;
      for (int k = 3; k <= 6; k++) begin
        arcm_r[k] <= arcm_r[k-1];
      end
      for (int k = 4; k <= 6; k++) begin
        mm_r[k] <= mm_r[k-1];
      end
      for (int k = 3; k <= 24; k++) begin
        aneg_r[k] <= aneg_r[k-1];
      end
      for (int k = 4; k <= 24; k++) begin
        mneg_r[k] <= mneg_r[k-1];
      end
      for (int k = 3; k <= 31; k++) begin
        date_r[k] <= date_r[k-1];
        tk_r[k]   <= tk_r[k-1];
      end
      // stages 19 to 24
      q_r[19]   <= q18;
      q_r[20]   <= q_r[19];
      lin_r[19] <= lin18;
      lon_r[19] <= lon18;
      sut_r[19] <= sut18;
      for (int k = 20; k <= 24; k++) begin
        lin_r[k] <= lin_r[k-1];
        lon_r[k] <= lon_r[k-1];
        sut_r[k] <= sut_r[k-1];
      end
      usc_r[21] <= p_usc[PW2-1:FB];
      for (int k = 22; k <= 24; k++) begin
        usc_r[k] <= usc_r[k-1];
      end
      c2_r[23] <= p_c2[PW2-1:FB];
      c2_r[24] <= c2_r[23];
      // stages 25 and 26
      sv25_r <= sv_c;
      a25_r  <= a_c;
      s26_r  <= sv25_r + a25_r;
      // stages 29 to 31
      whole29_r <= w_c;
      stk_r[29] <= p_stk[FB+22:FB];
      stk_r[30] <= stk_r[29];
      stk_r[31] <= stk_r[30];
      hr30_r    <= h_c;
      rem30_r   <= hr_c[11:0];
      hr31_r    <= hr30_r;
      mn31_r    <= mn_c;
      sc31_r    <= sr_c[5:0];
    end
  end

  assign out_ch.used_year  = date_r[NSTG][20:9];
  assign out_ch.used_month = date_r[NSTG][8:5];
  assign out_ch.used_day   = date_r[NSTG][4:0];
  assign out_ch.ut_ticks   = tk_r[NSTG];
  assign out_ch.sid_hour   = hr31_r;
  assign out_ch.sid_minute = mn31_r;
  assign out_ch.sid_second = sc31_r;
  assign out_ch.sid_ticks  = stk_r[NSTG];

endmodule

// File: hw/rtl/sidt_mul.sv
// Two-stage unsigned multiplier built from four half-width partial products.
// Depends on nothing; the caller gates both stages with its pipeline enable.
module sidt_mul #(
  parameter int AW = 48,
  parameter int BW = 48
) (
  input  logic              clk,
  input  logic              en,
  input  logic [AW-1:0]     a,
  input  logic [BW-1:0]     b,
  output logic [AW+BW-1:0]  p
);
  localparam int AL = AW / 2;
  localparam int AH = AW - AL;
  localparam int BL = BW / 2;
  localparam int BH = BW - BL;
  localparam int PW = AW + BW;

  logic [AL+BL-1:0] pll_r;
  logic [AL+BH-1:0] plh_r;
  logic [AH+BL-1:0] phl_r;
  logic [AH+BH-1:0] phh_r;
  logic [PW-1:0]    p_r;

  always_ff @(posedge clk) begin
    if (en) begin
      pll_r <= (AL+BL)'(a[AL-1:0]) * (AL+BL)'(b[BL-1:0]);
      plh_r <= (AL+BH)'(a[AL-1:0]) * (AL+BH)'(b[BW-1:BL]);
      phl_r <= (AH+BL)'(a[AW-1:AL]) * (AH+BL)'(b[BL-1:0]);
      phh_r <= (AH+BH)'(a[AW-1:AL]) * (AH+BH)'(b[BW-1:BL]);
      p_r   <= PW'(pll_r) + (PW'(plh_r) << BL) + (PW'(phl_r) << AL)
             + (PW'(phh_r) << (AL + BL));
    end
  end

  assign p = p_r;
endmodule

// File: hw/rtl/sidt_qdiv.sv
// Pipelined restoring divider giving floor(num * 2^FRAC_BITS / DEN) for num < DEN.
// Resolves STEP quotient bits per register stage. Depends on sidt_pkg.
module sidt_qdiv #(
  parameter logic [63:0] DEN  = 64'd73050,
  parameter int          STEP = 4
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic [$clog2(DEN)-1:0]          num,
  output logic [sidt_pkg::FRAC_BITS-1:0]  quo
);
  localparam int DW = $clog2(DEN);
  localparam int QW = sidt_pkg::FRAC_BITS;
  localparam int NS = QW / STEP;

  logic [DW-1:0] rem_r [NS];
  logic [QW-1:0] quo_r [NS];

  for (genvar g = 0; g < NS; g++) begin : g_st
    logic [DW-1:0] r_in;
    logic [QW-1:0] q_in;
    logic [DW-1:0] r_c;
    logic [QW-1:0] q_c;
    logic [DW:0]   x;

    if (g == 0) begin : g_first
      assign r_in = num;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = rem_r[g-1];
      assign q_in = quo_r[g-1];
    end

    always_comb begin
      r_c = r_in;
      q_c = q_in;
      x   = '0;
      for (int k = 0; k < STEP; k++) begin
        x = {r_c, 1'b0};
        if (x >= DEN[DW:0]) begin
          x   = x - DEN[DW:0];
          q_c = {q_c[QW-2:0], 1'b1};
        end else begin
          q_c = {q_c[QW-2:0], 1'b0};
        end
        r_c = x[DW-1:0];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[g] <= r_c;
        quo_r[g] <= q_c;
      end
    end
  end

  assign quo = quo_r[NS-1];
endmodule

// File: sim/tb.sv
// Self-checking testbench for sidereal_time_from_ut: random and directed UT dates and times.
// A scoreboard class predicts each sidereal result in fixed point and checks the output items.
// Depends on sidt_pkg, the sidt_in_if/sidt_out_if interfaces and the top-level RTL.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } ut_stamp_t;

  typedef struct {
    logic [11:0] used_year;
    logic [3:0]  used_month;
    logic [4:0]  used_day;
    logic [22:0] ut_ticks;
    logic [4:0]  sid_hour;
    logic [5:0]  sid_minute;
    logic [5:0]  sid_second;
    logic [22:0] sid_ticks;
  } sidereal_t;

  localparam logic [63:0] FMASK = (64'd1 << 48) - 64'd1;
  localparam int IDLE_LIMIT = 2000;

  class sidereal_scoreboard;
    int lon_deg;
    int unsigned lon_min;
    int unsigned lon_sec;
    sidereal_t pending_q[$];
    int errors;
    int checked;
    int unsigned month_start[13] = '{0, 0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

    function new();
      lon_deg = 0;
      lon_min = 0;
      lon_sec = 0;
      errors = 0;
      checked = 0;
    endfunction

    // Writes mirror the register widths: degrees are a signed 9-bit field.
    function void write_reg(int idx, logic [31:0] val);
      if (idx == 0) lon_deg = int'($signed(val[8:0]));
      else if (idx == 1) lon_min = val[5:0];
      else if (idx == 2) lon_sec = val[5:0];
    endfunction

    // floor(num * 2^48 / den), num below den.
    function logic [63:0] frac_div(logic [63:0] num, logic [63:0] den);
      logic [127:0] w;
      w = {64'd0, num} << 48;
      return 64'(w / {64'd0, den});
    endfunction

    function logic [63:0] mul_q(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = {64'd0, a} * {64'd0, b};
      return 64'(p >> 48);
    endfunction

    function longint smul_q(longint a, longint b);
      logic [63:0] ma;
      logic [63:0] mb;
      logic [63:0] r;
      ma = (a < 0) ? 64'(-a) : 64'(a);
      mb = (b < 0) ? 64'(-b) : 64'(b);
      r = mul_q(ma, mb);
      return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
    endfunction

    function sidereal_t compute_lmst(ut_stamp_t it);
      sidereal_t r;
      int unsigned yr, mo, da, hh, mi, se;
      longint arcsec, sub, j, m, t_q, t2, t3, minor_terms, lin_rem;
      logic [63:0] lon_q, sv, ticks, s_ut, s, whole;
      logic [127:0] p;
      yr = it.year; mo = it.month; da = it.day;
      hh = it.hour; mi = it.minute; se = it.second;
      if (yr <= 49) yr += 2000;
      else if (yr <= 99) yr += 1900;
      if (yr < 1950 || yr > 2050 || mo < 1 || mo > 12 || da < 1 || da > 31) begin
        yr = 1950; mo = 1; da = 1;
      end
      if (hh > 23 || mi > 59 || se > 59) begin
        hh = 0; mi = 0; se = 0;
      end
      arcsec = 0;
      if (lon_deg >= -180 && lon_deg <= 180 && lon_min <= 59 && lon_sec <= 59) begin
        sub = lon_min * 60 + lon_sec;
        arcsec = longint'(lon_deg) * 3600 + ((lon_deg < 0) ? -sub : sub);
      end
      lon_q = frac_div((arcsec < 0) ? 64'(-arcsec) : 64'(arcsec), 64'd1296000);
      if (arcsec < 0) lon_q = -lon_q;

      j = month_start[mo] + da - 1;
      if ((yr % 4) == 0 && mo > 2) j++;
      j += (longint'(yr) - 1949) / 4;
      j += (longint'(yr) - 1950) * 365;
      m = 2 * j - 36525;
      t_q = longint'(frac_div((m < 0) ? 64'(-m) : 64'(m), 64'd73050));
      if (m < 0) t_q = -t_q;

      // Linear term taken modulo one day before it becomes a fraction.
      lin_rem = (64'sd86401848 * m) % 64'sd63115200000;
      if (lin_rem < 0) lin_rem += 64'sd63115200000;

      t2 = smul_q(t_q, t_q);
      t3 = smul_q(t2, t_q);
      minor_terms = smul_q(longint'(frac_div(64'd93104, 64'd86400000000)), t2)
                  - smul_q(longint'(frac_div(64'd62, 64'd864000000000000)), t3);
      sv = frac_div(64'd24110548, 64'd86400000) + frac_div(64'(lin_rem), 64'd63115200000)
         + 64'(minor_terms);
      sv &= FMASK;

      ticks = 64'(hh * 3600 + mi * 60 + se) * 64'd5184000 / 64'd86400;
      s_ut = frac_div(ticks, 64'd5184000);
      s = sv + s_ut + mul_q(s_ut, frac_div(64'd2737845, 64'd1000000000));
      s = (s + lon_q) & FMASK;

      p = {64'd0, s} * 128'd86400;
      whole = 64'(p >> 48);
      if (p[47]) whole++;
      if (whole >= 86400) whole -= 86400;

      r.used_year  = 12'(yr);
      r.used_month = 4'(mo);
      r.used_day   = 5'(da);
      r.ut_ticks   = 23'(ticks);
      r.sid_hour   = 5'(whole / 3600);
      r.sid_minute = 6'((whole / 60) % 60);
      r.sid_second = 6'(whole % 60);
      r.sid_ticks  = 23'(mul_q(s, 64'd5184000));
      return r;
    endfunction

    function void note_input(ut_stamp_t it);
      pending_q.push_back(compute_lmst(it));
    endfunction

    function void check_result(sidereal_t got);
      sidereal_t exp_r;
      if (pending_q.size() == 0) begin
        $error("result item arrived with no expectation waiting");
        errors++;
        return;
      end
      exp_r = pending_q.pop_front();
      checked++;
      if (got.used_year !== exp_r.used_year) begin
        $error("used_year: expected %0d, got %0d", exp_r.used_year, got.used_year); errors++;
      end
      if (got.used_month !== exp_r.used_month) begin
        $error("used_month: expected %0d, got %0d", exp_r.used_month, got.used_month); errors++;
      end
      if (got.used_day !== exp_r.used_day) begin
        $error("used_day: expected %0d, got %0d", exp_r.used_day, got.used_day); errors++;
      end
      if (got.ut_ticks !== exp_r.ut_ticks) begin
        $error("ut_ticks: expected %0d, got %0d", exp_r.ut_ticks, got.ut_ticks); errors++;
      end
      if (got.sid_hour !== exp_r.sid_hour) begin
        $error("sid_hour: expected %0d, got %0d", exp_r.sid_hour, got.sid_hour); errors++;
      end
      if (got.sid_minute !== exp_r.sid_minute) begin
        $error("sid_minute: expected %0d, got %0d", exp_r.sid_minute, got.sid_minute); errors++;
      end
      if (got.sid_second !== exp_r.sid_second) begin
        $error("sid_second: expected %0d, got %0d", exp_r.sid_second, got.sid_second); errors++;
      end
      if (got.sid_ticks !== exp_r.sid_ticks) begin
        $error("sid_ticks: expected %0d, got %0d", exp_r.sid_ticks, got.sid_ticks); errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [3:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;
  bit no_gaps;
  int idle_cycles;
  int sent;

  sidt_in_if in_ch();
  sidt_out_if out_ch();
  sidereal_scoreboard sb;

  sidereal_time_from_ut u_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_gaps || r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Sink side: ready idles in random stretches.
  int stall_left;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready = 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      out_ch.ready = 1'b0;
      stall_left--;
    end else begin
      stall_left = pick_gap();
      out_ch.ready = (stall_left == 0);
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        sb.note_input('{in_ch.year, in_ch.month, in_ch.day, in_ch.hour, in_ch.minute,
                        in_ch.second});
      if (out_ch.valid && out_ch.ready)
        sb.check_result('{out_ch.used_year, out_ch.used_month, out_ch.used_day,
                          out_ch.ut_ticks, out_ch.sid_hour, out_ch.sid_minute,
                          out_ch.sid_second, out_ch.sid_ticks});
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || psel)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout after %0d idle cycles", idle_cycles);
        $display("sidereal_time_from_ut test failed");
        $finish;
      end
    end
  end

  task automatic send_stamp(ut_stamp_t it);
    int g;
    g = pick_gap();
    repeat (g) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
    end
    @(negedge clk);
    in_ch.valid  = 1'b1;
    in_ch.year   = it.year;
    in_ch.month  = it.month;
    in_ch.day    = it.day;
    in_ch.hour   = it.hour;
    in_ch.minute = it.minute;
    in_ch.second = it.second;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
  endtask

  task automatic write_reg(logic [1:0] idx, int val);
    @(negedge clk);
    psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = 32'(val);
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(idx, 32'(val));
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  // Wait out every outstanding result plus the pipeline depth before touching registers.
  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic set_longitude(int d, int mn, int sc);
    write_reg(sidt_pkg::REG_LON_DEG, d);
    write_reg(sidt_pkg::REG_LON_MIN, mn);
    write_reg(sidt_pkg::REG_LON_SEC, sc);
  endtask

  function automatic ut_stamp_t random_stamp();
    ut_stamp_t it;
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) it.year = 12'($urandom_range(1950, 2050));
    else if (r < 80) it.year = 12'($urandom_range(0, 99));
    else it.year = 12'($urandom);
    it.month  = ($urandom_range(0, 9) != 0) ? 4'($urandom_range(1, 12)) : 4'($urandom);
    it.day    = ($urandom_range(0, 9) != 0) ? 5'($urandom_range(1, 31)) : 5'($urandom);
    it.hour   = ($urandom_range(0, 9) != 0) ? 5'($urandom_range(0, 23)) : 5'($urandom);
    it.minute = ($urandom_range(0, 9) != 0) ? 6'($urandom_range(0, 59)) : 6'($urandom);
    it.second = ($urandom_range(0, 9) != 0) ? 6'($urandom_range(0, 59)) : 6'($urandom);
    return it;
  endfunction

  ut_stamp_t directed[$];
  int lon_set[8][3] = '{'{0, 0, 0}, '{180, 0, 0}, '{-180, 0, 0}, '{-1, 59, 59},
                        '{179, 59, 59}, '{-256, 63, 63}, '{255, 60, 0}, '{45, 30, 63}};

  initial begin
    sb = new();
    idle_cycles = 0;
    sent = 0;
    no_gaps = 0;
    rst_n = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    in_ch.valid = 1'b0;
    in_ch.year = '0; in_ch.month = '0; in_ch.day = '0;
    in_ch.hour = '0; in_ch.minute = '0; in_ch.second = '0;
    out_ch.ready = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Two-digit year edges, out-of-range dates and times, leap-day months.
    directed = '{
      '{12'd0, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0},
      '{12'd49, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59},
      '{12'd50, 4'd2, 5'd29, 5'd12, 6'd0, 6'd0},
      '{12'd99, 4'd3, 5'd1, 5'd6, 6'd30, 6'd30},
      '{12'd1949, 4'd6, 5'd15, 5'd1, 6'd2, 6'd3},
      '{12'd1950, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0},
      '{12'd2050, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59},
      '{12'd2051, 4'd5, 5'd5, 5'd5, 6'd5, 6'd5},
      '{12'd4095, 4'd15, 5'd31, 5'd31, 6'd63, 6'd63},
      '{12'd2000, 4'd0, 5'd10, 5'd10, 6'd10, 6'd10},
      '{12'd2000, 4'd13, 5'd10, 5'd10, 6'd10, 6'd10},
      '{12'd2000, 4'd7, 5'd0, 5'd10, 6'd10, 6'd10},
      '{12'd2000, 4'd2, 5'd31, 5'd24, 6'd0, 6'd0},
      '{12'd2024, 4'd3, 5'd1, 5'd23, 6'd60, 6'd0},
      '{12'd2023, 4'd3, 5'd1, 5'd23, 6'd0, 6'd60},
      '{12'd2024, 4'd2, 5'd29, 5'd18, 6'd45, 6'd12},
      '{12'd1999, 4'd12, 5'd31, 5'd23, 6'd59, 6'd59},
      '{12'd2048, 4'd11, 5'd30, 5'd0, 6'd0, 6'd1},
      '{12'd1987, 4'd9, 5'd31, 5'd21, 6'd7, 6'd42},
      '{12'd2012, 4'd4, 5'd31, 5'd31, 6'd0, 6'd0}
    };
    foreach (directed[i]) send_stamp(directed[i]);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      set_longitude(lon_set[ph][0], lon_set[ph][1], lon_set[ph][2]);
      no_gaps = (ph % 3 == 1);
      for (int n = 0; n < 150; n++) send_stamp(random_stamp());
      drain();
    end

    // Random longitudes, often a valid one.
    for (int ph = 0; ph < 4; ph++) begin
      set_longitude(int'($signed(9'($urandom))), $urandom_range(0, 63), $urandom_range(0, 63));
      no_gaps = 0;
      for (int n = 0; n < 50; n++) send_stamp(random_stamp());
      drain();
    end

    $display("%0d UT items sent and %0d sidereal results checked over 13 longitude settings",
             sent, sb.checked);
    $display("including invalid dates, times and longitudes with random stalls on both sides");
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("sidereal_time_from_ut test passed");
    end else begin
      $display("sidereal_time_from_ut test failed");
    end
    $finish;
  end
endmodule

// File: files.f
hw/rtl/sidt_pkg.sv
hw/rtl/sidt_if.sv
hw/rtl/sidt_mul.sv
hw/rtl/sidt_qdiv.sv
hw/rtl/sidereal_time_from_ut.sv
sim/tb.sv
